/* design/bavgd_pkg.sv */
package bavgd_pkg;

  // Sample format and block length limits
  localparam int SAMPLE_WIDTH = 32;
  localparam int MAX_FACTOR   = 64;
  localparam int NUM_LANES    = 6;
  localparam int STAMP_WIDTH  = 64;
  localparam int FACTOR_WIDTH = 7;

  // Sum grows by log2 of the longest block; active factor and sample count
  localparam int SUM_WIDTH    = SAMPLE_WIDTH + $clog2(MAX_FACTOR);
  localparam int AF_WIDTH     = $clog2(MAX_FACTOR + 1);
  localparam int DIV_CNT_W    = $clog2(SUM_WIDTH);

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic        [STAMP_WIDTH-1:0]  stamp_t;
  typedef logic        [AF_WIDTH-1:0]     afactor_t;

  // Per-lane control from the sequencer
  typedef struct packed {
    logic acc;   // accept one sample
    logic last;  // sample closes the block: start the divide
    logic clr;   // discard the open block
    logic ack;   // result taken by the output stage
  } lane_ctrl_t;

endpackage

/* design/bavgd_in_if.sv */
interface bavgd_in_if
  import bavgd_pkg::*;
;
  logic    valid;
  logic    ready;
  sample_t gyro_x;
  sample_t gyro_y;
  sample_t gyro_z;
  sample_t accel_x;
  sample_t accel_y;
  sample_t accel_z;
  stamp_t  stamp;

  modport source (
    output valid, gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z, stamp,
    input  ready
  );
  modport sink (
    input  valid, gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z, stamp,
    output ready
  );
endinterface

/* design/bavgd_out_if.sv */
interface bavgd_out_if
  import bavgd_pkg::*;
;
  logic    valid;
  logic    ready;
  sample_t mean_gyro_x;
  sample_t mean_gyro_y;
  sample_t mean_gyro_z;
  sample_t mean_accel_x;
  sample_t mean_accel_y;
  sample_t mean_accel_z;
  stamp_t  block_stamp;

  modport source (
    output valid, mean_gyro_x, mean_gyro_y, mean_gyro_z,
           mean_accel_x, mean_accel_y, mean_accel_z, block_stamp,
    input  ready
  );
  modport sink (
    input  valid, mean_gyro_x, mean_gyro_y, mean_gyro_z,
           mean_accel_x, mean_accel_y, mean_accel_z, block_stamp,
    output ready
  );
endinterface

/* design/bavgd_lane.sv */
module bavgd_lane
  import bavgd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  lane_ctrl_t ctrl_i,
  input  sample_t    sample_i,
  input  afactor_t   factor_i,
  output logic       done_o,
  output sample_t    mean_o
);

  logic signed [SUM_WIDTH-1:0] sum_q;
  logic signed [SUM_WIDTH-1:0] sum_nx;
  logic                        busy_q;
  logic                        done_q;
  logic [DIV_CNT_W-1:0]        cnt_q;

  // divider datapath: magnitude shifts out at the top, quotient in at the bottom
  logic [SUM_WIDTH-1:0]        mag_q;
  logic [AF_WIDTH-1:0]         rem_q;
  logic                        neg_q;
  logic [AF_WIDTH:0]           rem_sh;
  logic                        ge;
  logic [AF_WIDTH-1:0]         rem_nx;

  always_comb begin
    sum_nx = sum_q + SUM_WIDTH'(sample_i);
    rem_sh = {rem_q, mag_q[SUM_WIDTH-1]};
    ge     = (rem_sh >= {1'b0, factor_i});
    if (ge) begin
      rem_nx = AF_WIDTH'(rem_sh - {1'b0, factor_i});
    end else begin
      rem_nx = AF_WIDTH'(rem_sh);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      if (ctrl_i.clr) begin
        sum_q <= '0;
      end else if (ctrl_i.acc) begin
        sum_q <= ctrl_i.last ? '0 : sum_nx;
        if (ctrl_i.last) begin
          busy_q <= 1'b1;
          cnt_q  <= DIV_CNT_W'(SUM_WIDTH - 1);
        end
      end
      if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
      if (ctrl_i.ack) begin
        done_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.acc && ctrl_i.last && !ctrl_i.clr) begin
      neg_q <= sum_nx[SUM_WIDTH-1];
      mag_q <= sum_nx[SUM_WIDTH-1] ? SUM_WIDTH'(-sum_nx) : SUM_WIDTH'(sum_nx);
      rem_q <= '0;
    end else if (busy_q) begin
      mag_q <= {mag_q[SUM_WIDTH-2:0], ge};
      rem_q <= rem_nx;
    end
  end

  // restore sign; quotient always fits the sample width
  assign mean_o = neg_q ? SAMPLE_WIDTH'(SUM_WIDTH'(0) - mag_q) : SAMPLE_WIDTH'(mag_q);
  assign done_o = done_q;

endmodule

/* design/bavgd_merge.sv */
module bavgd_merge
  import bavgd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [NUM_LANES-1:0] done_i,
  input  sample_t             mean_i [NUM_LANES],
  input  stamp_t              stamp_i,
  output logic                load_o,
  bavgd_out_if.source         mean_o
);

  logic    valid_q;
  sample_t mean_q [NUM_LANES];
  stamp_t  stamp_q;

  // all lanes finish together; take the set when the output slot is free
  assign load_o = (&done_i) && (!valid_q || mean_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_o) begin
      valid_q <= 1'b1;
    end else if (mean_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_o) begin
      mean_q  <= mean_i;
      stamp_q <= stamp_i;
    end
  end

  assign mean_o.valid        = valid_q;
  assign mean_o.mean_gyro_x  = mean_q[0];
  assign mean_o.mean_gyro_y  = mean_q[1];
  assign mean_o.mean_gyro_z  = mean_q[2];
  assign mean_o.mean_accel_x = mean_q[3];
  assign mean_o.mean_accel_y = mean_q[4];
  assign mean_o.mean_accel_z = mean_q[5];
  assign mean_o.block_stamp  = stamp_q;

endmodule

/* design/block_average_decimator.sv */
// Channel    Dir  Contents                                       Handshake
// sample_i   in   gyro_x/y/z, accel_x/y/z (Q15.16), stamp (u64)  valid/ready
// mean_o     out  mean_gyro_*, mean_accel_* (Q15.16), block_stamp valid/ready
// cfg        in   decimation_factor (7 b)                        cfg_we_i
//
// A sample that does not close a block is taken without holding off the next
// request. A block-closing sample starts six lane dividers (restoring, one
// quotient bit per cycle over the 38-bit sum), so input is held off for the 38
// divide steps and the load into the output register, when that register is
// free; the next request is taken after the load.
// Reset empties the block and sets the factor to one. A stalled output only
// holds off input once a second block result is ready behind the first.
module block_average_decimator
  import bavgd_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  bavgd_in_if.sink                sample_i,
  bavgd_out_if.source             mean_o,
  input  logic                    cfg_we_i,
  input  logic [FACTOR_WIDTH-1:0] cfg_wdata_i
);

  logic [FACTOR_WIDTH-1:0] factor_q;
  afactor_t                factor_act;
  afactor_t                cnt_q;
  afactor_t                cnt_inc;
  logic                    busy_q;
  logic                    accept;
  logic                    last;
  logic                    load;
  stamp_t                  stamp_q;
  lane_ctrl_t              ctrl;
  sample_t                 samples [NUM_LANES];
  sample_t                 means   [NUM_LANES];
  logic [NUM_LANES-1:0]    done;

  // Effective factor: zero acts as one, large values saturate
  always_comb begin
    if (factor_q == '0) begin
      factor_act = AF_WIDTH'(1);
    end else if (32'(factor_q) > MAX_FACTOR) begin
      factor_act = AF_WIDTH'(MAX_FACTOR);
    end else begin
      factor_act = AF_WIDTH'(factor_q);
    end
  end

  assign sample_i.ready = !busy_q;
  assign accept         = sample_i.valid && !busy_q;
  assign cnt_inc        = cnt_q + 1'b1;
  assign last           = (cnt_inc >= factor_act);

  assign ctrl.acc  = accept;
  assign ctrl.last = last;
  assign ctrl.clr  = cfg_we_i;
  assign ctrl.ack  = load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      factor_q <= FACTOR_WIDTH'(1);
      cnt_q    <= '0;
      busy_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        // new factor discards the open block
        factor_q <= cfg_wdata_i;
        cnt_q    <= '0;
      end else if (accept) begin
        cnt_q <= last ? '0 : cnt_inc;
      end
      if (accept && last) begin
        busy_q <= 1'b1;
      end else if (load) begin
        busy_q <= 1'b0;
      end
    end
  end

  // timestamp of the block's closing sample
  always_ff @(posedge clk_i) begin
    if (accept && last) begin
      stamp_q <= sample_i.stamp;
    end
  end

  assign samples[0] = sample_i.gyro_x;
  assign samples[1] = sample_i.gyro_y;
  assign samples[2] = sample_i.gyro_z;
  assign samples[3] = sample_i.accel_x;
  assign samples[4] = sample_i.accel_y;
  assign samples[5] = sample_i.accel_z;

  // one accumulator plus serial divider per channel
  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    bavgd_lane u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl),
      .sample_i (samples[g]),
      .factor_i (factor_act),
      .done_o   (done[g]),
      .mean_o   (means[g])
    );
  end

  bavgd_merge u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .done_i  (done),
    .mean_i  (means),
    .stamp_i (stamp_q),
    .load_o  (load),
    .mean_o  (mean_o)
  );

endmodule
